// ===== hw/rtl/mt19937_keystream_mod29_decoder_assert.svh =====
// Assertion macros used by the decoder's sequencer (mtkd_ctrl.sv).
`ifndef MT19937_KEYSTREAM_MOD29_DECODER_ASSERT_SVH
`define MT19937_KEYSTREAM_MOD29_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MTKD_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mtkd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MTKD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mtkd: next-cycle check failed");

`endif

// ===== hw/rtl/mtkd_pkg.sv =====
// Package with the decoder's constants, codes, types and tempering function.
package mtkd_pkg;

  localparam int TABLE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int ALPHABET_DEF = 29;
  localparam int ADDR_W       = 10;
  localparam int SYM_W        = 5;
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 64;

  localparam logic [ADDR_W-1:0] POS_RESET = ADDR_W'(TABLE_WORDS + 1);
  localparam logic [ADDR_W-1:0] POS_FULL  = ADDR_W'(TABLE_WORDS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_WORDS - 1);

  localparam logic [31:0] TWIST_XOR = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc60000;
  localparam logic [31:0] LIN_MULT  = 32'd1812433253;
  localparam logic [31:0] ARR_MULT1 = 32'd1664525;
  localparam logic [31:0] ARR_MULT2 = 32'd1566083941;
  localparam logic [31:0] ARR_SEED  = 32'd19650218;
  localparam logic [31:0] HIGH_BIT  = 32'h80000000;
  localparam logic [31:0] LOW_BITS  = 32'h7fffffff;

  // Command codes of an input item.
  localparam logic CMD_RESEED = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Seeding kinds.
  localparam logic SEED_DIRECT = 1'b0;
  localparam logic SEED_ARRAY  = 1'b1;

  // Draw patterns; the unused code behaves as the top-byte pattern.
  localparam logic [1:0] DRAW_REJECT   = 2'd0;
  localparam logic [1:0] DRAW_FRACTION = 2'd1;
  localparam logic [1:0] DRAW_BYTE     = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SEED    = 2'd0;
  localparam logic [1:0] REG_KIND    = 2'd1;
  localparam logic [1:0] REG_PATTERN = 2'd2;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_LIN_MUL, ST_LIN_WR, ST_A1_RD, ST_A1_WR, ST_A2_RD, ST_A2_WR,
    ST_WRAP, ST_SEED_END, ST_DRAW, ST_TW_PRE, ST_TW_LOAD, ST_TW_RUN, ST_TEMP, ST_FRAC,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic [63:0] seed;
    logic        kind;
    logic [1:0]  pattern;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_req_t;

  // Standard MT19937 output tempering.
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hw/rtl/mtkd_chan_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface mtkd_in_if;
  import mtkd_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [SYM_W-1:0] cipher_symbol;
  modport source (output valid, cmd, cipher_symbol, input ready);
  modport sink (input valid, cmd, cipher_symbol, output ready);
endinterface

interface mtkd_out_if;
  import mtkd_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] key_symbol;
  logic [SYM_W-1:0] plain_symbol;
  modport source (output valid, key_symbol, plain_symbol, input ready);
  modport sink (input valid, key_symbol, plain_symbol, output ready);
endinterface

// ===== hw/rtl/mtkd_ram.sv =====
// Generator table: one write port and two registered read ports.
module mtkd_ram (
  input  logic              clk,
  input  mtkd_pkg::ram_req_t req,
  output logic [31:0]       rdata_a,
  output logic [31:0]       rdata_b
);
  import mtkd_pkg::*;

  logic [31:0] mem [TABLE_WORDS];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

// ===== hw/rtl/mtkd_cfg.sv =====
// APB-style configuration registers.
module mtkd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mtkd_pkg::PADDR_W-1:0] paddr,
  input  logic [mtkd_pkg::PDATA_W-1:0] pwdata,
  output logic [mtkd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output mtkd_pkg::cfg_t               cfg
);
  import mtkd_pkg::*;

  logic [63:0] seed_r;
  logic        kind_r;
  logic [1:0]  pattern_r;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[PADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes, masked to each register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= '0;
      kind_r    <= SEED_DIRECT;
      pattern_r <= DRAW_REJECT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SEED:    seed_r    <= pwdata;
        REG_KIND:    kind_r    <= pwdata[0];
        REG_PATTERN: pattern_r <= pwdata[1:0];
        default:     ;
      endcase
    end
  end

  // Read decode.
  always_comb begin
    unique case (reg_idx)
      REG_SEED:    prdata = seed_r;
      REG_KIND:    prdata = {63'd0, kind_r};
      REG_PATTERN: prdata = {62'd0, pattern_r};
      default:     prdata = '0;
    endcase
  end

  assign cfg = '{seed: seed_r, kind: kind_r, pattern: pattern_r};

endmodule

// ===== hw/rtl/mtkd_ctrl.sv =====
// Sequencer: table clearing, seeding, twist, word draw and key reduction.
`include "mt19937_keystream_mod29_decoder_assert.svh"

module mtkd_ctrl #(
  parameter int ALPHABET = mtkd_pkg::ALPHABET_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mtkd_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [mtkd_pkg::SYM_W-1:0] in_cipher,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mtkd_pkg::SYM_W-1:0] out_key,
  output logic [mtkd_pkg::SYM_W-1:0] out_plain,
  output mtkd_pkg::ram_req_t         ram_req,
  input  logic [31:0]                rdata_a,
  input  logic [31:0]                rdata_b
);
  import mtkd_pkg::*;

  localparam logic [5:0] ALPHA6 = 6'(ALPHABET);
  localparam logic [8:0] A8_1   = 9'(ALPHABET);
  localparam logic [8:0] A8_2   = 9'(ALPHABET * 2);
  localparam logic [8:0] A8_4   = 9'(ALPHABET * 4);
  localparam logic [8:0] A8_8   = 9'(ALPHABET * 8);
  localparam logic [6:0] A7_1   = 7'(ALPHABET);
  localparam logic [6:0] A7_2   = 7'(ALPHABET * 2);
  localparam logic [5:0] KEY_MAX = 6'(ALPHABET - 1);

  ctrl_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              arr_r, arr_nxt;
  logic              ph2_r, ph2_nxt;
  logic              j_r, j_nxt;
  logic              half_r, half_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       prev_r, prev_nxt;
  logic [31:0]       cur_r, cur_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic [26:0]       word1_r, word1_nxt;
  logic [58:0]       frac_p_r, frac_p_nxt;
  logic [SYM_W-1:0]  cipher_r, cipher_nxt;
  logic [SYM_W-1:0]  key_r, key_nxt;
  logic [SYM_W-1:0]  out_key_r, out_key_nxt;
  logic [SYM_W-1:0]  out_plain_r, out_plain_nxt;

  logic              in_fire;
  logic              out_free;
  logic [31:0]       temp_w;
  logic [SYM_W-1:0]  rej_sym;
  logic              rej_ok;
  logic [52:0]       frac_x;
  logic [31:0]       seed_word;
  logic              two_words;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [31:0]       twist_y;
  logic [31:0]       twist_new;
  logic [ADDR_W:0]   nx2_sum;
  logic [ADDR_W:0]   far_sum;
  logic [ADDR_W-1:0] nx2_addr;
  logic [ADDR_W-1:0] far_addr;

  // Top byte reduced by restoring subtraction; the byte stays below 16 * ALPHABET.
  function automatic logic [SYM_W-1:0] mod_byte(input logic [7:0] b);
    logic [8:0] v;
    v = {1'b0, b};
    if (v >= A8_8) v = v - A8_8;
    if (v >= A8_4) v = v - A8_4;
    if (v >= A8_2) v = v - A8_2;
    if (v >= A8_1) v = v - A8_1;
    return SYM_W'(v);
  endfunction

  // Cipher minus key, brought back into range; the sum stays below 4 * ALPHABET.
  function automatic logic [SYM_W-1:0] sub_mod(input logic [SYM_W-1:0] c,
                                               input logic [SYM_W-1:0] k);
    logic [6:0] v;
    v = 7'(c) + A7_1 - 7'(k);
    if (v >= A7_2) v = v - A7_2;
    if (v >= A7_1) v = v - A7_1;
    return SYM_W'(v);
  endfunction

  // Round the product to 53 significant bits, ties to even, then keep the integer part.
  function automatic logic [SYM_W-1:0] round_key(input logic [58:0] p);
    logic [5:0]  k;
    logic [58:0] q;
    logic [58:0] rem_v;
    logic [58:0] half_v;
    logic        up;
    k = 6'(p >> 53);
    for (int s = 1; s <= 6; s++) begin
      q      = p >> s;
      rem_v  = p & ((59'd1 << s) - 59'd1);
      half_v = 59'd1 << (s - 1);
      up     = (rem_v > half_v) || ((rem_v == half_v) && q[0]);
      q      = q + 59'(up);
      if (p[52+s]) k = 6'(q >> (53 - s));
    end
    if (k >= ALPHA6) k = KEY_MAX;
    return SYM_W'(k);
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_key   = out_key_r;
  assign out_plain = out_plain_r;

  // Word draw decode.
  assign temp_w  = temper(rdata_a);
  assign rej_sym = temp_w[31:27];
  assign rej_ok  = ({1'b0, rej_sym} < ALPHA6);
  assign frac_x  = {word1_r, temp_w[31:6]};

  // Array seeding word selection.
  assign two_words = |cfg.seed[63:32];
  assign seed_word = j_r ? cfg.seed[63:32] : cfg.seed[31:0];

  // Shared seeding multiplier operands.
  always_comb begin
    if (state_r == ST_LIN_MUL) begin
      mul_a = LIN_MULT;
    end else if (state_r == ST_A2_RD) begin
      mul_a = ARR_MULT2;
    end else begin
      mul_a = ARR_MULT1;
    end
    mul_b = prev_r ^ (prev_r >> 30);
  end

  // Twist of one word and the addresses for the next one.
  assign twist_y   = (cur_r & HIGH_BIT) | (rdata_a & LOW_BITS);
  assign twist_new = rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_XOR : 32'd0);
  assign nx2_sum   = {1'b0, idx_r} + (ADDR_W + 1)'(2);
  assign far_sum   = {1'b0, idx_r} + (ADDR_W + 1)'(TWIST_OFFSET + 1);
  assign nx2_addr  = (nx2_sum >= (ADDR_W + 1)'(TABLE_WORDS)) ?
                     ADDR_W'(nx2_sum - (ADDR_W + 1)'(TABLE_WORDS)) : ADDR_W'(nx2_sum);
  assign far_addr  = (far_sum >= (ADDR_W + 1)'(TABLE_WORDS)) ?
                     ADDR_W'(far_sum - (ADDR_W + 1)'(TABLE_WORDS)) : ADDR_W'(far_sum);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (idx_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) state_nxt = (in_cmd == CMD_RESEED) ? ST_LIN_MUL : ST_DRAW;
      end
      ST_LIN_MUL:  state_nxt = ST_LIN_WR;
      ST_LIN_WR: begin
        if (idx_r != LAST_ADDR) state_nxt = ST_LIN_MUL;
        else if (arr_r == SEED_ARRAY) state_nxt = ST_A1_RD;
        else state_nxt = ST_IDLE;
      end
      ST_A1_RD:    state_nxt = ST_A1_WR;
      ST_A1_WR: begin
        if (idx_r == LAST_ADDR) state_nxt = ST_WRAP;
        else if (cnt_r == ADDR_W'(1)) state_nxt = ST_A2_RD;
        else state_nxt = ST_A1_RD;
      end
      ST_A2_RD:    state_nxt = ST_A2_WR;
      ST_A2_WR: begin
        if (idx_r == LAST_ADDR) state_nxt = ST_WRAP;
        else if (cnt_r == ADDR_W'(1)) state_nxt = ST_SEED_END;
        else state_nxt = ST_A2_RD;
      end
      ST_WRAP:     state_nxt = ph2_r ? ST_A2_RD : ST_A1_RD;
      ST_SEED_END: state_nxt = ST_IDLE;
      ST_DRAW:     state_nxt = (pos_r >= POS_FULL) ? ST_TW_PRE : ST_TEMP;
      ST_TW_PRE:   state_nxt = ST_TW_LOAD;
      ST_TW_LOAD:  state_nxt = ST_TW_RUN;
      ST_TW_RUN:   if (idx_r == LAST_ADDR) state_nxt = ST_DRAW;
      ST_TEMP: begin
        case (cfg.pattern)
          DRAW_REJECT:   state_nxt = rej_ok ? ST_OUT : ST_DRAW;
          DRAW_FRACTION: state_nxt = half_r ? ST_FRAC : ST_DRAW;
          default:       state_nxt = ST_OUT;
        endcase
      end
      ST_FRAC:     state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory requests and result register.
  always_comb begin
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    arr_nxt       = arr_r;
    ph2_nxt       = ph2_r;
    j_nxt         = j_r;
    half_nxt      = half_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    prod_nxt      = prod_r;
    word1_nxt     = word1_r;
    frac_p_nxt    = frac_p_r;
    cipher_nxt    = cipher_r;
    key_nxt       = key_r;
    out_key_nxt   = out_key_r;
    out_plain_nxt = out_plain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_req       = '0;
    unique case (state_r)
      // Zero the table after reset.
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        idx_nxt       = idx_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          cipher_nxt = in_cipher;
          half_nxt   = 1'b0;
          if (in_cmd == CMD_RESEED) begin
            arr_nxt       = cfg.kind;
            prev_nxt      = (cfg.kind == SEED_ARRAY) ? ARR_SEED : cfg.seed[31:0];
            ram_req.we    = 1'b1;
            ram_req.waddr = '0;
            ram_req.wdata = (cfg.kind == SEED_ARRAY) ? ARR_SEED : cfg.seed[31:0];
            idx_nxt       = ADDR_W'(1);
          end
        end
      end
      ST_LIN_MUL: prod_nxt = 32'(mul_a * mul_b);
      // Linear seeding: one word from the previous one.
      ST_LIN_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        ram_req.wdata = prod_r + 32'(idx_r);
        prev_nxt      = prod_r + 32'(idx_r);
        if (idx_r != LAST_ADDR) begin
          idx_nxt = idx_r + ADDR_W'(1);
        end else if (arr_r == SEED_ARRAY) begin
          idx_nxt  = ADDR_W'(1);
          cnt_nxt  = ADDR_W'(TABLE_WORDS);
          ph2_nxt  = 1'b0;
          j_nxt    = 1'b0;
          prev_nxt = ARR_SEED;
        end else begin
          pos_nxt = POS_FULL;
        end
      end
      ST_A1_RD, ST_A2_RD: begin
        ram_req.raddr_a = idx_r;
        prod_nxt        = 32'(mul_a * mul_b);
      end
      // First mixing pass over the seed words.
      ST_A1_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        ram_req.wdata = (rdata_a ^ prod_r) + seed_word + 32'(j_r);
        prev_nxt      = (rdata_a ^ prod_r) + seed_word + 32'(j_r);
        j_nxt         = two_words ? !j_r : 1'b0;
        cnt_nxt       = cnt_r - ADDR_W'(1);
        if (idx_r != LAST_ADDR) begin
          idx_nxt = idx_r + ADDR_W'(1);
          if (cnt_r == ADDR_W'(1)) begin
            ph2_nxt = 1'b1;
            cnt_nxt = LAST_ADDR;
          end
        end
      end
      // Second mixing pass.
      ST_A2_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        ram_req.wdata = (rdata_a ^ prod_r) - 32'(idx_r);
        prev_nxt      = (rdata_a ^ prod_r) - 32'(idx_r);
        cnt_nxt       = cnt_r - ADDR_W'(1);
        if (idx_r != LAST_ADDR) idx_nxt = idx_r + ADDR_W'(1);
      end
      // Index wrap copies the last word to the first.
      ST_WRAP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = prev_r;
        idx_nxt       = ADDR_W'(1);
      end
      ST_SEED_END: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = HIGH_BIT;
        pos_nxt       = POS_FULL;
      end
      ST_DRAW: begin
        if (pos_r < POS_FULL) begin
          ram_req.raddr_a = pos_r;
          pos_nxt         = pos_r + ADDR_W'(1);
        end
      end
      ST_TW_PRE: ram_req.raddr_a = '0;
      ST_TW_LOAD: begin
        cur_nxt         = rdata_a;
        ram_req.raddr_a = ADDR_W'(1);
        ram_req.raddr_b = ADDR_W'(TWIST_OFFSET);
        idx_nxt         = '0;
      end
      // In-place twist, one word per cycle.
      ST_TW_RUN: begin
        ram_req.we      = 1'b1;
        ram_req.waddr   = idx_r;
        ram_req.wdata   = twist_new;
        cur_nxt         = rdata_a;
        ram_req.raddr_a = nx2_addr;
        ram_req.raddr_b = far_addr;
        idx_nxt         = idx_r + ADDR_W'(1);
        if (idx_r == LAST_ADDR) pos_nxt = '0;
      end
      // Reduce the tempered word by the draw pattern.
      ST_TEMP: begin
        case (cfg.pattern)
          DRAW_REJECT: if (rej_ok) key_nxt = rej_sym;
          DRAW_FRACTION: begin
            if (!half_r) begin
              word1_nxt = temp_w[31:5];
              half_nxt  = 1'b1;
            end else begin
              frac_p_nxt = 59'(frac_x) * 59'(ALPHABET);
            end
          end
          default: key_nxt = mod_byte(temp_w[31:24]);
        endcase
      end
      ST_FRAC: key_nxt = round_key(frac_p_r);
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = key_r;
          out_plain_nxt = sub_mod(cipher_r, key_r);
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      pos_r       <= POS_RESET;
      cnt_r       <= '0;
      arr_r       <= SEED_DIRECT;
      ph2_r       <= 1'b0;
      j_r         <= 1'b0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      arr_r       <= arr_nxt;
      ph2_r       <= ph2_nxt;
      j_r         <= j_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    prod_r      <= prod_nxt;
    word1_r     <= word1_nxt;
    frac_p_r    <= frac_p_nxt;
    cipher_r    <= cipher_nxt;
    key_r       <= key_nxt;
    out_key_r   <= out_key_nxt;
    out_plain_r <= out_plain_nxt;
  end

  // Read position never passes the twist-pending value.
  `MTKD_ASSERT_IMP(a_pos_range, 1'b1, pos_r <= POS_RESET)
  // An accepted item always leaves the idle state.
  `MTKD_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready)
  // A finished key lies inside the alphabet.
  `MTKD_ASSERT_IMP(a_key_range, state_r == ST_OUT, {1'b0, key_r} < ALPHA6)
  // The twist never writes beyond the table.
  `MTKD_ASSERT_IMP(a_twist_addr, state_r == ST_TW_RUN, idx_r <= LAST_ADDR)

endmodule

// ===== hw/rtl/mt19937_keystream_mod29_decoder.sv =====
// Top level of the MT19937 keystream decoder over a small alphabet.
//
//   Channel   Direction  Handshake              Payload
//   in_ch     input      valid/ready            cmd, cipher_symbol
//   out_ch    output     valid/ready            key_symbol, plain_symbol
//   cfg (APB) input      psel/penable, pready=1 seed_value, seeding_kind, draw_pattern
//
// One item is in work at a time. A decode accepts the item, draws tempered words through
// ST_DRAW and ST_TEMP and loads the result in ST_OUT; fraction keys draw two words and add
// a rounding state, rejection may draw several.
// A table twist runs first whenever the read position is spent.
// Reseeding loops over the table with a multiply state and a write state per word; array reseed adds two mixing passes.
// After reset a clearing pass zeroes all 624 table words before items are taken.
// A result waits in the output register; the next item is taken while it waits.
module mt19937_keystream_mod29_decoder #(
  parameter int ALPHABET = mtkd_pkg::ALPHABET_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mtkd_in_if.sink                      in_ch,
  mtkd_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mtkd_pkg::PADDR_W-1:0] paddr,
  input  logic [mtkd_pkg::PDATA_W-1:0] pwdata,
  output logic [mtkd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import mtkd_pkg::*;

  cfg_t        cfg;
  ram_req_t    ram_req;
  logic [31:0] rdata_a;
  logic [31:0] rdata_b;

  // Configuration registers.
  mtkd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Generator table.
  mtkd_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Sequencer.
  mtkd_ctrl #(
    .ALPHABET (ALPHABET)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .in_cipher (in_ch.cipher_symbol),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_key   (out_ch.key_symbol),
    .out_plain (out_ch.plain_symbol),
    .ram_req   (ram_req),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b)
  );

endmodule
